// ----- hdl/pmtp_pkg.sv -----
// Shared types, codes and character constants of the polynomial matrix text parser.
// No dependencies; imported by pmtp_core, polynomial_matrix_text_parser_unit and tb.
package pmtp_pkg;

   // parameter defaults
   localparam int MAX_VARS_DEF   = 8;
   localparam int EXP_BITS_DEF   = 8;
   localparam int DIM_BITS_DEF   = 10;
   localparam int HEADER_LEN_DEF = 9;

   // fixed field widths
   localparam int LANE      = 8;
   localparam int NUM_LANES = 8;
   localparam int EXP_W     = LANE * NUM_LANES;
   localparam int CNT_W     = 10;
   localparam int NV_W      = 4;
   localparam int ACC_W     = 8;
   localparam int VSEL_W    = 3;
   localparam int CODE_W    = 3;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = 10;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_NUM_VARS = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_NUM_ROWS = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_NUM_COLS = 2'd2;

   // register reset values
   localparam logic [NV_W-1:0]  NUM_VARS_RST = 4'd8;
   localparam logic [CNT_W-1:0] NUM_ROWS_RST = 10'd1;
   localparam logic [CNT_W-1:0] NUM_COLS_RST = 10'd1;

   typedef logic [7:0] char_type;

   // characters of the text format
   localparam char_type CH_ZERO  = 8'h30;
   localparam char_type CH_NINE  = 8'h39;
   localparam char_type CH_X     = 8'h78;
   localparam char_type CH_CARET = 8'h5E;
   localparam char_type CH_STAR  = 8'h2A;
   localparam char_type CH_PLUS  = 8'h2B;
   localparam char_type CH_MINUS = 8'h2D;
   localparam char_type CH_COMMA = 8'h2C;
   localparam char_type CH_CLOSE = 8'h7D;
   localparam char_type CH_SPACE = 8'h20;
   localparam char_type CH_TAB   = 8'h09;
   localparam char_type CH_CR    = 8'h0D;

   typedef enum logic [3:0] {
      PH_HDR, PH_ROWBEG, PH_CELL, PH_FACTOR, PH_COEF, PH_VIDX0, PH_VIDX,
      PH_POW0, PH_POW, PH_AFTER, PH_WS, PH_CLOSE, PH_SEP0, PH_SEP1, PH_SEP2,
      PH_HALT
   } phase_type;

   typedef enum logic [CODE_W-1:0] {
      ERR_NONE      = 3'd0,
      ERR_NUMBER    = 3'd1,
      ERR_DIGIT_X   = 3'd2,
      ERR_CLOSE     = 3'd3,
      ERR_VAR_RANGE = 3'd4
   } err_type;

   typedef struct packed {
      logic [NV_W-1:0]  num_vars;
      logic [CNT_W-1:0] num_rows;
      logic [CNT_W-1:0] num_cols;
   } cfg_type;

   typedef struct packed {
      logic             term_valid;
      logic [EXP_W-1:0] exponents;
      logic [CNT_W-1:0] row;
      logic [CNT_W-1:0] col;
      logic             cell_end;
      err_type          error_code;
   } rsp_type;

   function automatic logic is_digit(char_type c);
      return c inside {[CH_ZERO:CH_NINE]};
   endfunction

   function automatic logic is_space(char_type c);
      return (c == CH_SPACE) || (c inside {[CH_TAB:CH_CR]});
   endfunction

endpackage

// ----- hdl/pmtp_core.sv -----
// Parser state and one-character transition logic of the polynomial matrix text parser.
// Depends on pmtp_pkg.
module pmtp_core
   import pmtp_pkg::*;
#(
   parameter int MAX_VARS   = MAX_VARS_DEF,
   parameter int EXP_BITS   = EXP_BITS_DEF,
   parameter int DIM_BITS   = DIM_BITS_DEF,
   parameter int HEADER_LEN = HEADER_LEN_DEF
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     step_en,
   input  char_type char_in,
   input  cfg_type  cfg,
   output logic     rsp_emit,
   output rsp_type  rsp
);

   localparam int SKIP_W = (HEADER_LEN < 1) ? 1 : $clog2(HEADER_LEN + 1);
   localparam logic [SKIP_W-1:0] SKIP_INIT = SKIP_W'(HEADER_LEN);
   localparam logic [ACC_W-1:0]  EXP_MAX   = ACC_W'((1 << EXP_BITS) - 1);
   localparam logic [ACC_W-1:0]  IDX_MAX   = {ACC_W{1'b1}};
   localparam logic [NV_W-1:0]   MAX_NV    = NV_W'(MAX_VARS);
   localparam logic [CNT_W-1:0]  DIM_MASK  =
      (DIM_BITS >= CNT_W) ? {CNT_W{1'b1}} : CNT_W'((32'd1 << DIM_BITS) - 32'd1);
   localparam int PROD_W = ACC_W + 4;
   localparam logic [PROD_W-1:0] DEC_BASE = PROD_W'(10);

   typedef logic [MAX_VARS-1:0][EXP_BITS-1:0] exps_type;

   phase_type         phase_ff, phase_in;
   exps_type          exps_ff, exps_in;
   logic              zero_ff, zero_in;
   logic [ACC_W-1:0]  acc_ff, acc_in;
   logic [VSEL_W-1:0] vsel_ff, vsel_in;
   logic [CNT_W-1:0]  row_ff, row_in;
   logic [CNT_W-1:0]  col_ff, col_in;
   logic [SKIP_W-1:0] skip_ff, skip_in;

   // build a result item; lanes at or above the variable count read zero
   function automatic rsp_type mk_rsp(logic valid, logic cend, err_type code,
                                      logic [CNT_W-1:0] r, logic [CNT_W-1:0] c,
                                      exps_type e, logic [NV_W-1:0] nv);
      rsp_type t;
      t.term_valid = valid;
      t.exponents  = '0;
      if (valid) begin
         for (int k = 0; k < MAX_VARS; k++) begin
            if (NV_W'(k) < nv) t.exponents[k*LANE +: LANE] = LANE'(e[k]);
         end
      end
      t.row        = r & DIM_MASK;
      t.col        = c & DIM_MASK;
      t.cell_end   = cend;
      t.error_code = code;
      return t;
   endfunction

   // transition for one character: entry phases fall through, then one terminal phase
   always_comb begin
      logic              done;
      logic              dig;
      logic              spc;
      logic [NV_W-1:0]   eff;
      logic [ACC_W-1:0]  dval;
      logic [PROD_W-1:0] prod;
      logic [CNT_W:0]    col_p1;
      rsp_type           held;

      phase_in = phase_ff;
      exps_in  = exps_ff;
      zero_in  = zero_ff;
      acc_in   = acc_ff;
      vsel_in  = vsel_ff;
      row_in   = row_ff;
      col_in   = col_ff;
      skip_in  = skip_ff;
      rsp_emit = 1'b0;
      rsp      = '0;
      done     = 1'b0;
      held     = '0;

      dig    = is_digit(char_in);
      spc    = is_space(char_in);
      eff    = (cfg.num_vars > MAX_NV) ? MAX_NV : cfg.num_vars;
      dval   = ACC_W'(char_in - CH_ZERO);
      prod   = PROD_W'(acc_ff) * DEC_BASE + PROD_W'(dval);
      col_p1 = {1'b0, col_ff} + {{CNT_W{1'b0}}, 1'b1};

      if (step_en) begin
         // header skip
         if (phase_in == PH_HDR) begin
            if (skip_in != '0) begin
               skip_in = skip_in - SKIP_W'(1);
               done    = 1'b1;
            end else begin
               phase_in = PH_ROWBEG;
            end
         end
         // row separator
         if (!done && phase_in == PH_SEP0) begin
            if (char_in == CH_COMMA) begin
               phase_in = PH_SEP1;
               done     = 1'b1;
            end else begin
               phase_in = PH_ROWBEG;
            end
         end
         // whitespace between cells
         if (!done && phase_in == PH_WS) begin
            if (spc) done = 1'b1;
            else phase_in = (col_in < cfg.num_cols) ? PH_CELL : PH_CLOSE;
         end
         // row start
         if (!done && phase_in == PH_ROWBEG) begin
            if (row_in >= cfg.num_rows) begin
               phase_in = PH_HALT;
               done     = 1'b1;
            end else begin
               col_in   = '0;
               exps_in  = '0;
               zero_in  = 1'b0;
               phase_in = (cfg.num_cols == '0) ? PH_CLOSE : PH_CELL;
            end
         end
         // cell start, optional leading minus
         if (!done && phase_in == PH_CELL) begin
            exps_in  = '0;
            zero_in  = 1'b0;
            phase_in = PH_FACTOR;
            if (char_in == CH_MINUS) done = 1'b1;
         end
         // coefficient digits
         if (!done && phase_in == PH_COEF) begin
            if (dig) done = 1'b1;
            else phase_in = PH_AFTER;
         end
         // variable index digits
         if (!done && phase_in == PH_VIDX) begin
            if (dig) begin
               acc_in = (prod > PROD_W'(IDX_MAX)) ? IDX_MAX : prod[ACC_W-1:0];
               done   = 1'b1;
            end else if (acc_ff == '0 || acc_ff > ACC_W'(eff)) begin
               rsp_emit = 1'b1;
               rsp      = mk_rsp(1'b0, 1'b0, ERR_VAR_RANGE, row_in, col_in, '0, eff);
               phase_in = PH_HALT;
               done     = 1'b1;
            end else begin
               vsel_in = VSEL_W'(acc_ff - ACC_W'(1));
               if (char_in == CH_CARET) begin
                  phase_in = PH_POW0;
                  done     = 1'b1;
               end else begin
                  for (int k = 0; k < MAX_VARS; k++) begin
                     if (!zero_in && vsel_in == VSEL_W'(k)) exps_in[k] = EXP_BITS'(1);
                  end
                  phase_in = PH_AFTER;
               end
            end
         end
         // exponent digits
         if (!done && phase_in == PH_POW) begin
            if (dig) begin
               acc_in = (prod > PROD_W'(EXP_MAX)) ? EXP_MAX : prod[ACC_W-1:0];
               done   = 1'b1;
            end else begin
               for (int k = 0; k < MAX_VARS; k++) begin
                  if (!zero_in && vsel_in == VSEL_W'(k)) exps_in[k] = acc_ff[EXP_BITS-1:0];
               end
               phase_in = PH_AFTER;
            end
         end

         // terminal phases
         if (!done) begin
            case (phase_in)
               PH_FACTOR: begin
                  if (char_in == CH_ZERO) begin
                     zero_in  = 1'b1;
                     phase_in = PH_AFTER;
                  end else if (dig) begin
                     phase_in = PH_COEF;
                  end else if (char_in == CH_X) begin
                     phase_in = PH_VIDX0;
                  end else begin
                     rsp_emit = 1'b1;
                     rsp      = mk_rsp(1'b0, 1'b0, ERR_DIGIT_X, row_in, col_in, '0, eff);
                     phase_in = PH_HALT;
                  end
               end
               PH_VIDX0, PH_POW0: begin
                  if (!dig) begin
                     rsp_emit = 1'b1;
                     rsp      = mk_rsp(1'b0, 1'b0, ERR_NUMBER, row_in, col_in, '0, eff);
                     phase_in = PH_HALT;
                  end else begin
                     acc_in   = dval;
                     phase_in = (phase_in == PH_VIDX0) ? PH_VIDX : PH_POW;
                  end
               end
               PH_AFTER: begin
                  if (char_in == CH_STAR) begin
                     phase_in = PH_FACTOR;
                  end else if (char_in == CH_PLUS || char_in == CH_MINUS) begin
                     rsp_emit = !zero_in;
                     rsp      = mk_rsp(1'b1, 1'b0, ERR_NONE, row_in, col_in, exps_in, eff);
                     exps_in  = '0;
                     zero_in  = 1'b0;
                     phase_in = PH_FACTOR;
                  end else if (char_in == CH_COMMA || char_in == CH_CLOSE || spc) begin
                     // cell end
                     held     = mk_rsp(!zero_in, 1'b1, ERR_NONE, row_in, col_in, exps_in, eff);
                     exps_in  = '0;
                     zero_in  = 1'b0;
                     col_in   = col_p1[CNT_W-1:0];
                     phase_in = PH_WS;
                     rsp_emit = 1'b1;
                     rsp      = held;
                     if (char_in == CH_CLOSE) begin
                        if (col_in < cfg.num_cols) begin
                           // row closed before its last column
                           rsp      = mk_rsp(1'b0, 1'b0, ERR_DIGIT_X, row_in, col_in, '0, eff);
                           phase_in = PH_HALT;
                        end else begin
                           row_in   = row_in + CNT_W'(1);
                           col_in   = '0;
                           phase_in = PH_SEP0;
                        end
                     end
                  end else begin
                     rsp_emit = 1'b1;
                     rsp      = mk_rsp(1'b0, 1'b0,
                                       (col_p1 >= {1'b0, cfg.num_cols}) ? ERR_CLOSE : ERR_DIGIT_X,
                                       row_in, col_in, '0, eff);
                     phase_in = PH_HALT;
                  end
               end
               PH_CLOSE: begin
                  if (char_in != CH_CLOSE) begin
                     rsp_emit = 1'b1;
                     rsp      = mk_rsp(1'b0, 1'b0, ERR_CLOSE, row_in, col_in, '0, eff);
                     phase_in = PH_HALT;
                  end else begin
                     row_in   = row_in + CNT_W'(1);
                     col_in   = '0;
                     phase_in = PH_SEP0;
                  end
               end
               PH_SEP1: phase_in = PH_SEP2;
               PH_SEP2: phase_in = PH_ROWBEG;
               default: phase_in = PH_HALT;
            endcase
         end
      end
   end

   // parser state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HDR;
         exps_ff  <= '0;
         zero_ff  <= 1'b0;
         acc_ff   <= '0;
         vsel_ff  <= '0;
         row_ff   <= '0;
         col_ff   <= '0;
         skip_ff  <= SKIP_INIT;
      end else begin
         phase_ff <= phase_in;
         exps_ff  <= exps_in;
         zero_ff  <= zero_in;
         acc_ff   <= acc_in;
         vsel_ff  <= vsel_in;
         row_ff   <= row_in;
         col_ff   <= col_in;
         skip_ff  <= skip_in;
      end
   end

   // an error result always parks the parser
   a_error_halts: assert property (@(posedge clock) disable iff (reset)
      rsp_emit && rsp.error_code != ERR_NONE |=> phase_ff == PH_HALT)
      else $error("parser did not halt after an error item");

   // a halted parser produces nothing
   a_halt_silent: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_HALT |-> !rsp_emit)
      else $error("result item while halted");

   // header characters never produce an item
   a_header_silent: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_HDR && skip_ff != '0 |-> !rsp_emit && phase_in == PH_HDR)
      else $error("header character left header skip");

endmodule

// ----- hdl/polynomial_matrix_text_parser_unit.sv -----
// Top level of the polynomial matrix text parser: channels, registers, input and result stages.
// Depends on pmtp_pkg and pmtp_core.
//
//   channel  direction  handshake           payload
//   req      in         req_valid/req_stall req_char_in
//   rsp      out        rsp_valid/rsp_stall term_valid, exponents, row, col, cell_end,
//                                           error_code
//   csr      in         csr_write           csr_index, csr_wdata
//
// One character per cycle unless the result side stalls: an item accepted into the input
// register is parsed from it, and its result item, if any, is loaded into the result
// register, which raises rsp_valid. The parser state registers take their next state
// from combinational logic, so a new item is taken every cycle unless req_stall is high.
// Reset (synchronous) restores header skip; no clearing pass is needed.
// A stalled result only holds the input register when it also holds an item.
module polynomial_matrix_text_parser_unit
   import pmtp_pkg::*;
#(
   parameter int MAX_VARS   = MAX_VARS_DEF,
   parameter int EXP_BITS   = EXP_BITS_DEF,
   parameter int DIM_BITS   = DIM_BITS_DEF,
   parameter int HEADER_LEN = HEADER_LEN_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [7:0]           req_char_in,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic                 rsp_term_valid,
   output logic [EXP_W-1:0]     rsp_exponents,
   output logic [CNT_W-1:0]     rsp_row,
   output logic [CNT_W-1:0]     rsp_col,
   output logic                 rsp_cell_end,
   output logic [CODE_W-1:0]    rsp_error_code,
   input  logic                 csr_write,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_DAT_W-1:0] csr_wdata
);

   cfg_type  cfg_ff, cfg_in;
   logic     s1_vld_ff, s1_vld_in;
   char_type s1_char_ff;
   logic     rsp_valid_ff, rsp_valid_in;
   rsp_type  rsp_ff;
   logic     out_free, advance, req_accept;
   logic     core_emit, rsp_load;
   rsp_type  core_rsp;

   // configuration writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (csr_index)
            CSR_NUM_VARS: cfg_in.num_vars = csr_wdata[NV_W-1:0];
            CSR_NUM_ROWS: cfg_in.num_rows = csr_wdata[CNT_W-1:0];
            CSR_NUM_COLS: cfg_in.num_cols = csr_wdata[CNT_W-1:0];
            default:      cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.num_vars <= NUM_VARS_RST;
         cfg_ff.num_rows <= NUM_ROWS_RST;
         cfg_ff.num_cols <= NUM_COLS_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // handshake between input register and result register
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign advance    = s1_vld_ff && out_free;
   assign req_stall  = s1_vld_ff && !out_free;
   assign req_accept = req_valid && !req_stall;
   assign rsp_load   = advance && core_emit;

   always_comb begin
      s1_vld_in = s1_vld_ff;
      if (req_accept) s1_vld_in = 1'b1;
      else if (advance) s1_vld_in = 1'b0;
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) rsp_valid_in = 1'b1;
      else if (!rsp_stall) rsp_valid_in = 1'b0;
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) s1_vld_ff <= 1'b0;
      else s1_vld_ff <= s1_vld_in;
      if (req_accept) s1_char_ff <= req_char_in;
   end

   pmtp_core #(
      .MAX_VARS   (MAX_VARS),
      .EXP_BITS   (EXP_BITS),
      .DIM_BITS   (DIM_BITS),
      .HEADER_LEN (HEADER_LEN)
   ) u_core (
      .clock    (clock),
      .reset    (reset),
      .step_en  (advance),
      .char_in  (s1_char_ff),
      .cfg      (cfg_ff),
      .rsp_emit (core_emit),
      .rsp      (core_rsp)
   );

   // result register
   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else rsp_valid_ff <= rsp_valid_in;
      if (rsp_load) rsp_ff <= core_rsp;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_term_valid = rsp_ff.term_valid;
   assign rsp_exponents  = rsp_ff.exponents;
   assign rsp_row        = rsp_ff.row;
   assign rsp_col        = rsp_ff.col;
   assign rsp_cell_end   = rsp_ff.cell_end;
   assign rsp_error_code = rsp_ff.error_code;

endmodule

// ----- verif/tb.sv -----
// Self-checking testbench for polynomial_matrix_text_parser_unit: drives matrix text one
// character per item, predicts every term, cell end and error item, and compares them in order.
// Depends on pmtp_pkg and the parser RTL.
module tb;
   import pmtp_pkg::*;

   localparam int EXP_MAX = (1 << EXP_BITS_DEF) - 1;

   logic                 clock       = 1'b0;
   logic                 reset       = 1'b1;
   logic                 req_valid   = 1'b0;
   logic                 req_stall;
   logic [7:0]           req_char_in = 8'd0;
   logic                 rsp_valid;
   logic                 rsp_stall   = 1'b0;
   logic                 rsp_term_valid;
   logic [EXP_W-1:0]     rsp_exponents;
   logic [CNT_W-1:0]     rsp_row;
   logic [CNT_W-1:0]     rsp_col;
   logic                 rsp_cell_end;
   logic [CODE_W-1:0]    rsp_error_code;
   logic                 csr_write   = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index   = '0;
   logic [CSR_DAT_W-1:0] csr_wdata   = '0;

   polynomial_matrix_text_parser_unit DUT (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_char_in    (req_char_in),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_term_valid (rsp_term_valid),
      .rsp_exponents  (rsp_exponents),
      .rsp_row        (rsp_row),
      .rsp_col        (rsp_col),
      .rsp_cell_end   (rsp_cell_end),
      .rsp_error_code (rsp_error_code),
      .csr_write      (csr_write),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   // parser shadow state and register copies
   phase_type        parse_phase;
   logic [LANE-1:0]  lane_exp [NUM_LANES];
   bit               zero_term;
   int unsigned      num_acc;
   logic [2:0]       var_sel;
   logic [CNT_W-1:0] row_idx;
   logic [CNT_W-1:0] col_idx;
   int               header_left;
   logic [NV_W-1:0]  cfg_vars;
   logic [CNT_W-1:0] cfg_rows;
   logic [CNT_W-1:0] cfg_cols;

   rsp_type  expected_terms [$];
   char_type text_q [$];
   int       error_count = 0;
   int       chars_sent  = 0;
   bit       no_idle     = 1'b0;
   bit       long_hold   = 1'b0;
   bit       long_active = 1'b0;

   // clock
   initial begin
      forever #6 clock = ~clock;
   end

   // run limit
   initial begin
      #(12 * 400000);
      $display("Simulation FAILED");
      $finish;
   end

   function automatic bit char_is_digit(char_type c);
      return (c >= CH_ZERO) && (c <= CH_NINE);
   endfunction

   function automatic bit char_is_blank(char_type c);
      return (c == CH_SPACE) || ((c >= 8'd9) && (c <= 8'd13));
   endfunction

   function automatic int active_vars();
      return (cfg_vars > MAX_VARS_DEF) ? MAX_VARS_DEF : int'(cfg_vars);
   endfunction

   task automatic clear_term();
      for (int k = 0; k < NUM_LANES; k++) lane_exp[k] = '0;
      zero_term = 1'b0;
   endtask

   task automatic push_result(input bit valid, input bit cend, input err_type code);
      rsp_type r;
      r.term_valid = valid;
      r.exponents  = '0;
      if (valid) begin
         for (int k = 0; k < active_vars(); k++) r.exponents[k*LANE +: LANE] = lane_exp[k];
      end
      r.row        = row_idx;
      r.col        = col_idx;
      r.cell_end   = cend;
      r.error_code = code;
      expected_terms.insert(expected_terms.size(), r);
   endtask

   task automatic halt_with(input err_type code);
      push_result(1'b0, 1'b0, code);
      parse_phase = PH_HALT;
   endtask

   // advance the shadow parser by one accepted character
   task automatic parse_char(input char_type c);
      bit          done;
      int unsigned v;
      done = 1'b0;
      for (int guard = 0; guard < 16 && !done; guard++) begin
         case (parse_phase)
            PH_HDR: begin
               if (header_left > 0) begin
                  header_left--;
                  done = 1'b1;
               end else parse_phase = PH_ROWBEG;
            end
            PH_ROWBEG: begin
               if (row_idx >= cfg_rows) begin
                  parse_phase = PH_HALT;
                  done = 1'b1;
               end else begin
                  col_idx = '0;
                  clear_term();
                  parse_phase = (cfg_cols == 0) ? PH_CLOSE : PH_CELL;
               end
            end
            PH_CELL: begin
               clear_term();
               parse_phase = PH_FACTOR;
               if (c == CH_MINUS) done = 1'b1;
            end
            PH_FACTOR: begin
               done = 1'b1;
               if (c == CH_ZERO) begin
                  zero_term = 1'b1;
                  parse_phase = PH_AFTER;
               end else if (char_is_digit(c)) parse_phase = PH_COEF;
               else if (c == CH_X) parse_phase = PH_VIDX0;
               else halt_with(ERR_DIGIT_X);
            end
            PH_COEF: begin
               if (char_is_digit(c)) done = 1'b1;
               else parse_phase = PH_AFTER;
            end
            PH_VIDX0, PH_POW0: begin
               done = 1'b1;
               if (!char_is_digit(c)) halt_with(ERR_NUMBER);
               else begin
                  num_acc = int'(c) - int'(CH_ZERO);
                  parse_phase = (parse_phase == PH_VIDX0) ? PH_VIDX : PH_POW;
               end
            end
            PH_VIDX: begin
               if (char_is_digit(c)) begin
                  v = num_acc * 10 + (int'(c) - int'(CH_ZERO));
                  num_acc = (v > 255) ? 255 : v;
                  done = 1'b1;
               end else if (num_acc == 0 || num_acc > active_vars()) begin
                  halt_with(ERR_VAR_RANGE);
                  done = 1'b1;
               end else begin
                  var_sel = 3'(num_acc - 1);
                  if (c == CH_CARET) begin
                     parse_phase = PH_POW0;
                     done = 1'b1;
                  end else begin
                     if (!zero_term) lane_exp[var_sel] = 8'd1;
                     parse_phase = PH_AFTER;
                  end
               end
            end
            PH_POW: begin
               if (char_is_digit(c)) begin
                  v = num_acc * 10 + (int'(c) - int'(CH_ZERO));
                  num_acc = (v > EXP_MAX) ? EXP_MAX : v;
                  done = 1'b1;
               end else begin
                  if (!zero_term) lane_exp[var_sel] = 8'(num_acc);
                  parse_phase = PH_AFTER;
               end
            end
            PH_AFTER: begin
               done = 1'b1;
               if (c == CH_STAR) parse_phase = PH_FACTOR;
               else if (c == CH_PLUS || c == CH_MINUS) begin
                  if (!zero_term) push_result(1'b1, 1'b0, ERR_NONE);
                  clear_term();
                  parse_phase = PH_FACTOR;
               end else if (c == CH_COMMA || c == CH_CLOSE || char_is_blank(c)) begin
                  // an early close reports only the error item
                  if (c != CH_CLOSE || col_idx + 10'd1 >= cfg_cols)
                     push_result(!zero_term, 1'b1, ERR_NONE);
                  clear_term();
                  col_idx = col_idx + 10'd1;
                  if (c != CH_CLOSE) parse_phase = PH_WS;
                  else if (col_idx < cfg_cols) halt_with(ERR_DIGIT_X);
                  else begin
                     row_idx = row_idx + 10'd1;
                     col_idx = '0;
                     parse_phase = PH_SEP0;
                  end
               end else begin
                  halt_with((int'(col_idx) + 1 >= int'(cfg_cols)) ? ERR_CLOSE : ERR_DIGIT_X);
               end
            end
            PH_WS: begin
               if (char_is_blank(c)) done = 1'b1;
               else parse_phase = (col_idx < cfg_cols) ? PH_CELL : PH_CLOSE;
            end
            PH_CLOSE: begin
               done = 1'b1;
               if (c != CH_CLOSE) halt_with(ERR_CLOSE);
               else begin
                  row_idx = row_idx + 10'd1;
                  col_idx = '0;
                  parse_phase = PH_SEP0;
               end
            end
            PH_SEP0: begin
               if (c == CH_COMMA) begin
                  parse_phase = PH_SEP1;
                  done = 1'b1;
               end else parse_phase = PH_ROWBEG;
            end
            PH_SEP1: begin
               parse_phase = PH_SEP2;
               done = 1'b1;
            end
            PH_SEP2: begin
               parse_phase = PH_ROWBEG;
               done = 1'b1;
            end
            default: begin
               parse_phase = PH_HALT;
               done = 1'b1;
            end
         endcase
      end
   endtask

   // send one character item, with a random gap before it unless no_idle is set
   task automatic send_char(input char_type c);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 5);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_char_in <= c;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      parse_char(c);
      chars_sent++;
   endtask

   task automatic send_text();
      while (text_q.size() > 0) send_char(text_q.pop_front());
   endtask

   // let all expected items drain, then give the pipeline time to settle
   task automatic wait_idle();
      int waited;
      waited = 0;
      req_valid <= 1'b0;
      while (expected_terms.size() != 0 && waited < 5000) begin
         @(posedge clock);
         waited++;
      end
      if (expected_terms.size() != 0) begin
         $display("%0t: %0d expected result items never arrived", $time,
                  expected_terms.size());
         error_count++;
         expected_terms.delete();
      end
      repeat (12) @(posedge clock);
   endtask

   // write all three registers; upper bits of the variable count are junk
   task automatic set_config(input int vars_val, input int rows_val, input int cols_val);
      csr_write <= 1'b1;
      csr_index <= CSR_NUM_VARS;
      csr_wdata <= {6'($urandom_range(0, 63)), 4'(vars_val)};
      @(posedge clock);
      cfg_vars = 4'(vars_val);
      csr_index <= CSR_NUM_ROWS;
      csr_wdata <= 10'(rows_val);
      @(posedge clock);
      cfg_rows = 10'(rows_val);
      csr_index <= CSR_NUM_COLS;
      csr_wdata <= 10'(cols_val);
      @(posedge clock);
      cfg_cols = 10'(cols_val);
      csr_write <= 1'b0;
   endtask

   // text builders
   task automatic put_char(input char_type c);
      text_q.insert(text_q.size(), c);
   endtask

   task automatic add_str(input string s);
      for (int i = 0; i < s.len(); i++) put_char(char_type'(s[i]));
   endtask

   task automatic add_blank();
      int pick;
      pick = $urandom_range(0, 5);
      put_char((pick == 5) ? CH_SPACE : char_type'(9 + pick));
   endtask

   task automatic add_number(input int unsigned val, input bit pad);
      if (pad) repeat ($urandom_range(1, 2)) put_char(CH_ZERO);
      add_str($sformatf("%0d", val));
   endtask

   task automatic add_term();
      int factors;
      int pick;
      factors = $urandom_range(1, 3);
      for (int f = 0; f < factors; f++) begin
         if (f > 0) put_char(CH_STAR);
         pick = $urandom_range(0, 99);
         if (pick < 8) put_char(CH_ZERO);
         else if (pick < 25) begin
            // coefficient, never with a leading zero
            put_char(char_type'(CH_ZERO + $urandom_range(1, 9)));
            repeat ($urandom_range(0, 3)) put_char(char_type'(CH_ZERO + $urandom_range(0, 9)));
         end else begin
            put_char(CH_X);
            add_number($urandom_range(1, active_vars()), $urandom_range(0, 6) == 0);
            if ($urandom_range(0, 9) < 6) begin
               put_char(CH_CARET);
               pick = $urandom_range(0, 9);
               add_number((pick < 7) ? $urandom_range(0, 20) :
                          (pick < 9) ? $urandom_range(21, 255) : $urandom_range(256, 99999),
                          $urandom_range(0, 6) == 0);
            end
         end
      end
   endtask

   task automatic add_cell();
      int terms;
      terms = $urandom_range(1, 3);
      if ($urandom_range(0, 3) == 0) put_char(CH_MINUS);
      for (int t = 0; t < terms; t++) begin
         if (t > 0) put_char($urandom_range(0, 1) ? CH_PLUS : CH_MINUS);
         add_term();
      end
   endtask

   task automatic add_row(input int cols);
      int ending;
      if (cols == 0) put_char(CH_CLOSE);
      for (int k = 0; k < cols; k++) begin
         add_cell();
         if (k < cols - 1) begin
            if ($urandom_range(0, 2) != 0) begin
               put_char(CH_COMMA);
               repeat ($urandom_range(0, 2)) add_blank();
            end else repeat ($urandom_range(1, 2)) add_blank();
         end else begin
            ending = $urandom_range(0, 2);
            if (ending == 1) begin
               put_char(CH_COMMA);
               repeat ($urandom_range(0, 2)) add_blank();
            end else if (ending == 2) repeat ($urandom_range(1, 2)) add_blank();
            put_char(CH_CLOSE);
         end
      end
      // optional row separator, the two characters after the comma are free
      if ($urandom_range(0, 1)) begin
         put_char(CH_COMMA);
         repeat (2) put_char(char_type'($urandom_range(0, 255)));
      end
   endtask

   // result item checks
   task automatic report_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
         error_count++;
      end
   endtask

   initial begin : result_sink
      int      hold_left;
      rsp_type want;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (rsp_valid && !rsp_stall) begin
            if (expected_terms.size() == 0) begin
               $display("%0t: unexpected result item, expected none, actual row %0d col %0d code %0d",
                        $time, rsp_row, rsp_col, rsp_error_code);
               error_count++;
            end else begin
               want = expected_terms.pop_front();
               report_field("term_valid", want.term_valid, rsp_term_valid);
               report_field("exponents", want.exponents, rsp_exponents);
               report_field("row", want.row, rsp_row);
               report_field("col", want.col, rsp_col);
               report_field("cell_end", want.cell_end, rsp_cell_end);
               report_field("error_code", want.error_code, rsp_error_code);
            end
            hold_left = no_idle ? 0 : $urandom_range(0, 5);
         end
         // short random hold-off, or the long one from the timer below
         if (hold_left > 0 || long_active) begin
            rsp_stall <= 1'b1;
            if (hold_left > 0) hold_left--;
         end else rsp_stall <= 1'b0;
      end
   end

   // long hold-off so the parser backs up into its input
   initial begin : long_stall_timer
      forever begin
         @(posedge clock);
         if (long_hold) begin
            long_hold   = 1'b0;
            long_active = 1'b1;
            repeat (300) @(posedge clock);
            long_active = 1'b0;
         end
      end
   end

   // tests
   task automatic test_header();
      set_config(8, 1023, 2);
      put_char(8'hFF);
      put_char(8'h00);
      repeat (HEADER_LEN_DEF - 2) put_char(char_type'($urandom_range(0, 255)));
      send_text();
   endtask

   // leading minus, saturation, coefficient, repeated variable, zero factor, blank separators
   task automatic test_term_forms();
      add_str("-x1^255*x8^999+7*x2*x2^3-0*x4,x5}, {x01 \t0}");
      send_text();
   endtask

   task automatic test_zero_columns();
      wait_idle();
      set_config(8, 1023, 0);
      add_str("}, {}");
      send_text();
   endtask

   task automatic test_variable_limits();
      wait_idle();
      set_config(1, 1023, 1);
      add_str("x1^0}");
      send_text();
      wait_idle();
      set_config(15, 1023, 1);
      add_str("x8^1+x3}");
      send_text();
   endtask

   task automatic test_wide_row();
      int cols;
      cols = 40;
      wait_idle();
      set_config(8, 1023, cols);
      for (int k = 0; k < cols; k++) begin
         case ($urandom_range(0, 2))
            0:       put_char(CH_ZERO);
            1:       add_str("x1");
            default: add_str("7");
         endcase
         if (k == cols - 1) put_char(CH_CLOSE);
         else put_char($urandom_range(0, 1) ? CH_COMMA : CH_SPACE);
      end
      send_text();
   endtask

   task automatic test_backpressure();
      wait_idle();
      set_config(8, 1023, 4);
      no_idle   = 1'b1;
      long_hold = 1'b1;
      repeat (6) add_str("x1,x2^3,7,x8}");
      send_text();
      no_idle = 1'b0;
   endtask

   task automatic test_random_rows();
      int start;
      int rows;
      int nv;
      int cols;
      start = chars_sent;
      while (chars_sent - start < 180) begin
         wait_idle();
         case ($urandom_range(0, 3))
            0:       nv = 1;
            1:       nv = 8;
            2:       nv = $urandom_range(9, 15);
            default: nv = $urandom_range(1, 8);
         endcase
         cols = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 4);
         set_config(nv, 1023, cols);
         rows = $urandom_range(1, 4);
         repeat (rows) begin
            no_idle = ($urandom_range(0, 3) == 0);
            add_row(cols);
            send_text();
         end
      end
      no_idle = 1'b0;
   endtask

   // one terminal event: row limit or an error, then noise that must be ignored
   task automatic test_halt();
      wait_idle();
      case ($urandom_range(0, 5))
         0: set_config(cfg_vars, 1, cfg_cols);
         1: add_str("x^");
         2: add_str("x1*+");
         3: begin
            set_config(8, 1023, 3);
            add_str("x1}");
         end
         4: begin
            set_config(8, 1023, 1);
            add_str("x2;");
         end
         default: begin
            set_config(8, 1023, 2);
            case ($urandom_range(0, 2))
               0:       add_str("x9 ");
               1:       add_str("x0*");
               default: add_str("x300^");
            endcase
         end
      endcase
      repeat (40) put_char(char_type'($urandom_range(0, 255)));
      send_text();
   endtask

   initial begin
      // shadow state after reset
      parse_phase = PH_HDR;
      clear_term();
      num_acc     = 0;
      var_sel     = '0;
      row_idx     = '0;
      col_idx     = '0;
      header_left = HEADER_LEN_DEF;
      cfg_vars    = NUM_VARS_RST;
      cfg_rows    = NUM_ROWS_RST;
      cfg_cols    = NUM_COLS_RST;

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_header();
      test_term_forms();
      test_zero_columns();
      test_variable_limits();
      test_wide_row();
      test_backpressure();
      test_random_rows();
      test_halt();

      wait_idle();
      repeat (20) @(posedge clock);
      if (error_count == 0) $display("Simulation PASSED");
      else $display("Simulation FAILED");
      $finish;
   end

endmodule

// ----- sim.f -----
hdl/pmtp_pkg.sv
hdl/pmtp_core.sv
hdl/polynomial_matrix_text_parser_unit.sv
verif/tb.sv
